/* hdl/txrbo_pkg.sv */
// Shared constants and codes for the transmit ring buffer with overrun marker.
// No dependencies; imported by the slot RAM and the core.
package txrbo_pkg;

    localparam int BYTE_W         = 8;
    localparam int FREE_W         = 7;
    localparam int SLOT_COUNT_DEF = 128;
    localparam int FREE_SAT       = 127;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h21;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_READY = 1'b1
    } t_action;

endpackage

/* hdl/txrbo_slot_ram.sv */
// Byte slot memory: one write port, one read port with registered read data.
// Depends on txrbo_pkg for the byte width.
module txrbo_slot_ram import txrbo_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int AW         = $clog2(SLOT_COUNT)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [SLOT_COUNT];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/tx_ring_buffer_overrun_mark_core.sv */
// Top level of the transmit byte queue with overrun marker.
// Depends on txrbo_pkg and instantiates txrbo_slot_ram.
//
// Usage: the request channel (i_req_valid / o_req_stall) carries one
// transaction per item: i_action selects a byte push or a transmitter-ready
// event, i_push_byte is the byte to queue. The result channel
// (o_res_valid / i_res_stall) returns exactly one transaction per item with
// accepted, marker_queued, out_valid, out_byte, send_request and free_slots.
// A push with one usable slot left queues '!' instead and reports not
// accepted; a push into a full ring changes nothing.
// The result is registered when the request is taken and appears in the
// cycle after; the popped byte comes from the registered read port of the
// slot RAM. Throughput: one item per cycle while no pending result is stalled.
// Pointers and occupancy live in flops and update at acceptance, so the
// single RAM write or read per item sets the pace.
// Reset clears pointers, occupancy, the request flag and the result valid;
// slot contents are not cleared. While the receiver stalls a pending result,
// o_req_stall is high and the result holds.
module tx_ring_buffer_overrun_mark_core import txrbo_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_push_byte,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic              o_accepted,
    output logic              o_marker_queued,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_send_request,
    output logic [FREE_W-1:0] o_free_slots
);

    localparam int AW = $clog2(SLOT_COUNT);

    logic [AW-1:0]     r_wr_idx, n_wr_idx;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic [AW-1:0]     r_count,  n_count;
    logic              r_flag,   n_flag;
    logic              r_res_valid;
    logic              r_accepted, r_marker, r_popped, r_send;
    logic [FREE_W-1:0] r_free;

    logic              acc, is_push, do_store, do_pop;
    logic [AW:0]       free_now, free_next;
    logic [AW+7:0]     free_ext;
    logic [FREE_W-1:0] free_sat;
    logic [BYTE_W-1:0] store_byte, rd_data;

    assign o_req_stall = r_res_valid && i_res_stall;
    assign acc         = i_req_valid && !o_req_stall;
    assign is_push     = (t_action'(i_action) == ACT_PUSH);

    assign free_now   = (AW+1)'(SLOT_COUNT - 1) - {1'b0, r_count};
    assign do_store   = acc && is_push && (free_now != '0);
    assign do_pop     = acc && !is_push && (r_count != '0);
    assign store_byte = (free_now >= (AW+1)'(2)) ? i_push_byte : MARKER_BYTE;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        n_flag   = r_flag;
        if (do_store) begin
            n_wr_idx = (r_wr_idx == AW'(SLOT_COUNT - 1)) ? '0 : r_wr_idx + AW'(1);
            n_count  = r_count + AW'(1);
            n_flag   = 1'b1;
        end else if (do_pop) begin
            n_rd_idx = (r_rd_idx == AW'(SLOT_COUNT - 1)) ? '0 : r_rd_idx + AW'(1);
            n_count  = r_count - AW'(1);
        end else if (acc && !is_push) begin
            // ready on an empty ring drops the request
            n_flag = 1'b0;
        end
    end

    assign free_next = (AW+1)'(SLOT_COUNT - 1) - {1'b0, n_count};
    assign free_ext  = (AW+8)'(free_next);
    assign free_sat  = (free_ext > (AW+8)'(FREE_SAT)) ? FREE_W'(FREE_SAT)
                                                      : free_ext[FREE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_flag      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_flag   <= n_flag;
            if (acc) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_accepted <= is_push && (free_now >= (AW+1)'(2));
            r_marker   <= is_push && (free_now == (AW+1)'(1));
            r_popped   <= do_pop;
            r_send     <= n_flag;
            r_free     <= free_sat;
        end
    end

    txrbo_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_store),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (store_byte),
        .i_rd_en   (do_pop),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    assign o_res_valid     = r_res_valid;
    assign o_accepted      = r_accepted;
    assign o_marker_queued = r_marker;
    assign o_out_valid     = r_popped;
    assign o_out_byte      = r_popped ? rd_data : '0;
    assign o_send_request  = r_send;
    assign o_free_slots    = r_free;

`ifndef ASSERT_OFF
    logic [AW:0] occ_chk;
    assign occ_chk = (r_wr_idx >= r_rd_idx)
                   ? {1'b0, r_wr_idx} - {1'b0, r_rd_idx}
                   : (AW+1)'(SLOT_COUNT) - {1'b0, r_rd_idx} + {1'b0, r_wr_idx};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= AW'(SLOT_COUNT - 1))
        else $error("occupancy beyond usable slots");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_chk == {1'b0, r_count})
        else $error("pointers disagree with occupancy");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && is_push && r_count == AW'(SLOT_COUNT - 1))
        |=> (!o_accepted && !o_marker_queued && $stable(r_count)))
        else $error("push into full ring changed the queue");

    a_store_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> (r_flag && o_send_request))
        else $error("queued byte did not raise request");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_accepted && o_marker_queued) &&
                        !(o_out_valid && (o_accepted || o_marker_queued)))
        else $error("conflicting result flags");
`endif

endmodule
